// ===== rtl/phac_pkg.sv =====
package phac_pkg;

  // table depth default
  localparam int SOURCE_SLOTS_DEF = 256;

  // header size guards, bytes
  localparam int unsigned ETH_BYTES     = 14;
  localparam int unsigned IP_MIN_BYTES  = 20;
  localparam int unsigned TCP_MIN_BYTES = 20;
  localparam int unsigned UDP_HDR_BYTES = 8;

  // frame limits
  localparam logic [15:0] FRAME_MIN     = 16'd40;
  localparam logic [15:0] FRAME_MAX     = 16'd1500;
  localparam logic [15:0] UDP_FRAME_MIN = 16'd50;
  localparam logic [15:0] UDP_FRAME_MAX = 16'd576;
  localparam logic [7:0]  ICMP_TYPE_MAX = 8'd18;

  // TCP flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;
  localparam int FLAG_URG = 5;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd100;
  localparam logic [15:0] WINDOW_RST    = 16'd10;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  typedef enum logic [1:0] {
    PROTO_OTHER = 2'd0,
    PROTO_TCP   = 2'd1,
    PROTO_UDP   = 2'd2,
    PROTO_ICMP  = 2'd3
  } proto_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] start;
  } rate_entry_t;

  typedef struct packed {
    logic flag;
    logic empty;
    logic size;
    logic icmp;
  } alerts_t;

endpackage

// ===== rtl/phac_rate_table.sv =====
module phac_rate_table import phac_pkg::*; #(
  parameter int SLOTS = SOURCE_SLOTS_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,     // transfer accepted: read entry for it
  input  logic [AW-1:0] rd_addr,
  input  logic          upd_en,    // item in flight leaves and uses this table
  input  logic [AW-1:0] upd_addr,
  input  logic [31:0]   now,
  input  cfg_t          cfg,
  output logic          alert,
  output logic          busy
);

  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  rate_entry_t mem [SLOTS];
  rate_entry_t rd_word;
  rate_entry_t byp_word;
  logic        byp_hit;
  logic [AW-1:0] clr_cnt;
  logic        clearing;

  rate_entry_t cur;
  rate_entry_t upd_word;
  logic [31:0] elapsed;
  logic [15:0] cnt_inc;

  assign busy = clearing;

  // read at accept; a write to the same entry at that edge is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      byp_word <= upd_word;
      byp_hit  <= upd_en && (upd_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (upd_en) begin
      mem[upd_addr] <= upd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    cur      = byp_hit ? byp_word : rd_word;
    elapsed  = now - cur.start;
    cnt_inc  = (cur.count == 16'hFFFF) ? cur.count : cur.count + 16'd1;
    upd_word = cur;
    alert    = 1'b0;
    if (cur.count == 16'd0) begin
      upd_word.count = 16'd1;
      upd_word.start = now;
    end else if (elapsed > {16'd0, cfg.window}) begin
      upd_word.count = 16'd1;
      upd_word.start = now;
    end else if (cnt_inc > cfg.threshold) begin
      upd_word.count = 16'd0;
      alert          = 1'b1;
    end else begin
      upd_word.count = cnt_inc;
    end
  end

endmodule

// ===== rtl/phac_checks.sv =====
module phac_checks import phac_pkg::*; (
  input  proto_t      proto,
  input  logic [15:0] frame_length,
  input  logic [3:0]  ip_header_words,
  input  logic [15:0] ip_total_length,
  input  logic [3:0]  tcp_offset_words,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [15:0] udp_length,
  input  logic [7:0]  icmp_type,
  output alerts_t     alerts
);

  logic [5:0]  ihl;
  logic [5:0]  toff;
  logic [16:0] frame;
  logic        syn, fin, rst_f, ack, urg;
  logic        tcp_guard, bad_flags;

  always_comb begin
    ihl   = {ip_header_words, 2'b00};
    toff  = {tcp_offset_words, 2'b00};
    frame = {1'b0, frame_length};
    fin   = tcp_flag_bits[FLAG_FIN];
    syn   = tcp_flag_bits[FLAG_SYN];
    rst_f = tcp_flag_bits[FLAG_RST];
    ack   = tcp_flag_bits[FLAG_ACK];
    urg   = tcp_flag_bits[FLAG_URG];

    tcp_guard = frame >= 17'(ETH_BYTES + TCP_MIN_BYTES) + 17'(ihl);
    bad_flags = (syn && fin) || (syn && rst_f) || (fin && !ack) || (urg && !ack);

    alerts = '0;
    unique case (proto)
      PROTO_TCP: begin
        alerts.flag  = bad_flags && tcp_guard &&
                       (frame >= 17'(ETH_BYTES + IP_MIN_BYTES + TCP_MIN_BYTES));
        alerts.empty = tcp_guard && (frame >= 17'(ETH_BYTES + IP_MIN_BYTES)) &&
                       (ip_total_length == 16'({1'b0, ihl} + {1'b0, toff}));
      end
      PROTO_UDP: begin
        alerts.empty = (udp_length == 16'(UDP_HDR_BYTES)) &&
                       (frame >= 17'(ETH_BYTES + IP_MIN_BYTES + UDP_HDR_BYTES)) &&
                       (frame >= 17'(ETH_BYTES + UDP_HDR_BYTES) + 17'(ihl));
        alerts.size  = (frame_length < UDP_FRAME_MIN) || (frame_length > UDP_FRAME_MAX);
      end
      PROTO_ICMP: begin
        alerts.icmp = (icmp_type > ICMP_TYPE_MAX) &&
                      (frame >= 17'(ETH_BYTES + IP_MIN_BYTES + 4));
      end
      default: begin
      end
    endcase
    if ((frame_length < FRAME_MIN) || (frame_length > FRAME_MAX)) begin
      alerts.size = 1'b1;
    end
  end

endmodule

// ===== rtl/packet_heuristic_anomaly_checker.sv =====
// Packet heuristic anomaly checker: takes one parsed packet header per
// transfer on the s_ stream and returns one verdict transfer on the m_
// stream. Per source slot a fixed-window packet-rate counter is kept, TCP
// and ICMP in a shared table and UDP in its own; when the count in a window
// goes above rate_threshold, rate_alert is raised and the count cleared.
// TCP flags, empty payloads, frame sizes and ICMP types are also checked.
// One header is taken every clock while no table is being swept and the
// m_ stream does not stall: the table entry is read at accept, the
// verdict and the write-back are done as the header leaves the s1 stage,
// and a write to the same slot is forwarded to a header straight behind.
// After reset each table is cleared, one entry a cycle, with s_tready low.
// Registers (APB, pready always high): 0x0 rate_threshold, 0x4
// window_seconds, both 16 bits in pwdata[15:0]; paddr[2] selects.
module packet_heuristic_anomaly_checker import phac_pkg::*; #(
  parameter int SOURCE_SLOTS = SOURCE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // header in: protocol[1:0], frame_length[17:2], ip_header_words[21:18],
  // ip_total_length[37:22], tcp_offset_words[41:38], tcp_flag_bits[49:42],
  // udp_length[65:50], icmp_type[73:66], source_slot[81:74],
  // time_seconds[113:82], zero[119:114]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,
  // verdict out: suspicious[0], rate_alert[1], flag_alert[2], empty_alert[3],
  // size_alert[4], icmp_alert[5], zero[7:6]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.window    <= WINDOW_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_THRESHOLD: cfg.threshold <= pwdata[15:0];
        REG_WINDOW:    cfg.window    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {16'd0, cfg.threshold};
      REG_WINDOW:    prdata = {16'd0, cfg.window};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // slot folding: source_slot modulo SOURCE_SLOTS as a constant table
  // ---------------------------------------------------------------------
  logic [AW-1:0] slot_map [256];

  for (genvar i = 0; i < 256; i++) begin : g_slot_map
    localparam int MAPPED = i % SOURCE_SLOTS;
    assign slot_map[i] = AW'(MAPPED);
  end

  // ---------------------------------------------------------------------
  // handshake and stage registers
  // ---------------------------------------------------------------------
  logic          s_accept;
  logic          s1_valid;
  logic          s1_advance;
  logic          out_valid;
  logic          busy_shared, busy_udp;

  proto_t        s1_proto;
  logic [15:0]   s1_frame_length;
  logic [3:0]    s1_ip_header_words;
  logic [15:0]   s1_ip_total_length;
  logic [3:0]    s1_tcp_offset_words;
  logic [7:0]    s1_tcp_flag_bits;
  logic [15:0]   s1_udp_length;
  logic [7:0]    s1_icmp_type;
  logic [AW-1:0] s1_slot;
  logic [31:0]   s1_time;

  logic [AW-1:0] in_slot;

  assign in_slot    = slot_map[s_tdata[81:74]];
  assign s1_advance = s1_valid && (!out_valid || m_tready);
  assign s_tready   = !busy_shared && !busy_udp && (!s1_valid || s1_advance);
  assign s_accept   = s_tvalid && s_tready;
  assign m_tvalid   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_proto            <= proto_t'(s_tdata[1:0]);
      s1_frame_length     <= s_tdata[17:2];
      s1_ip_header_words  <= s_tdata[21:18];
      s1_ip_total_length  <= s_tdata[37:22];
      s1_tcp_offset_words <= s_tdata[41:38];
      s1_tcp_flag_bits    <= s_tdata[49:42];
      s1_udp_length       <= s_tdata[65:50];
      s1_icmp_type        <= s_tdata[73:66];
      s1_slot             <= in_slot;
      s1_time             <= s_tdata[113:82];
    end
  end

  // ---------------------------------------------------------------------
  // rate tables: TCP and ICMP share one, UDP has its own
  // ---------------------------------------------------------------------
  logic use_shared, use_udp;
  logic alert_shared, alert_udp;
  logic rate_alert;

  assign use_shared = (s1_proto == PROTO_TCP) || (s1_proto == PROTO_ICMP);
  assign use_udp    = (s1_proto == PROTO_UDP);
  assign rate_alert = (use_shared && alert_shared) || (use_udp && alert_udp);

  phac_rate_table #(.SLOTS(SOURCE_SLOTS)) u_shared_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_accept),
    .rd_addr  (in_slot),
    .upd_en   (s1_advance && use_shared),
    .upd_addr (s1_slot),
    .now      (s1_time),
    .cfg      (cfg),
    .alert    (alert_shared),
    .busy     (busy_shared)
  );

  phac_rate_table #(.SLOTS(SOURCE_SLOTS)) u_udp_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_accept),
    .rd_addr  (in_slot),
    .upd_en   (s1_advance && use_udp),
    .upd_addr (s1_slot),
    .now      (s1_time),
    .cfg      (cfg),
    .alert    (alert_udp),
    .busy     (busy_udp)
  );

  // ---------------------------------------------------------------------
  // header checks and verdict register
  // ---------------------------------------------------------------------
  alerts_t hdr_alerts;

  phac_checks u_checks (
    .proto            (s1_proto),
    .frame_length     (s1_frame_length),
    .ip_header_words  (s1_ip_header_words),
    .ip_total_length  (s1_ip_total_length),
    .tcp_offset_words (s1_tcp_offset_words),
    .tcp_flag_bits    (s1_tcp_flag_bits),
    .udp_length       (s1_udp_length),
    .icmp_type        (s1_icmp_type),
    .alerts           (hdr_alerts)
  );

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= {2'b00, hdr_alerts.icmp, hdr_alerts.size, hdr_alerts.empty,
                  hdr_alerts.flag, rate_alert,
                  rate_alert || (|hdr_alerts)};
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import phac_pkg::*;

  // run limit in clock cycles, far above the slowest correct run
  localparam int unsigned RUN_LIMIT = 400000;

  // register byte addresses
  localparam logic [2:0] ADDR_THRESHOLD = 3'h0;
  localparam logic [2:0] ADDR_WINDOW    = 3'h4;

  // ICMP header bytes needed before the type can be trusted
  localparam int unsigned ICMP_HDR_BYTES = 4;

  // verdict bit positions on m_tdata
  localparam int V_SUSP  = 0;
  localparam int V_RATE  = 1;
  localparam int V_FLAG  = 2;
  localparam int V_EMPTY = 3;
  localparam int V_SIZE  = 4;
  localparam int V_ICMP  = 5;

  // TCP flag masks
  localparam logic [7:0] F_FIN = 8'd1 << FLAG_FIN;
  localparam logic [7:0] F_SYN = 8'd1 << FLAG_SYN;
  localparam logic [7:0] F_RST = 8'd1 << FLAG_RST;
  localparam logic [7:0] F_ACK = 8'd1 << FLAG_ACK;
  localparam logic [7:0] F_URG = 8'd1 << FLAG_URG;

  // one parsed header, packed so that proto lands in the lowest bits of s_tdata
  typedef struct packed {
    logic [31:0] now_s;
    logic [7:0]  slot;
    logic [7:0]  icmp_type;
    logic [15:0] udp_len;
    logic [7:0]  flags;
    logic [3:0]  tcp_off;
    logic [15:0] ip_len;
    logic [3:0]  ihl_words;
    logic [15:0] frame_len;
    proto_t      proto;
  } hdr_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // protocol, frame_length, ip_header_words, ip_total_length, tcp_offset_words,
  // tcp_flag_bits, udp_length, icmp_type, source_slot, time_seconds, zero fill
  logic [119:0] s_tdata  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // suspicious, rate_alert, flag_alert, empty_alert, size_alert, icmp_alert, zero fill
  logic [7:0]   m_tdata;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  packet_heuristic_anomaly_checker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // headers waiting to go out, verdicts waiting to come back
  hdr_t        hdr_q[$];
  logic [5:0]  verdict_q[$];
  int unsigned hdrs_queued = 0;
  int unsigned hdrs_taken  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;

  // handshake flags seen at the last rising edge, read by the drivers
  logic hdr_xfer = 1'b0;
  logic res_xfer = 1'b0;

  // sender and receiver pacing
  int unsigned src_gap    = 0;
  bit          src_lazy   = 1'b1;
  int unsigned sink_wait  = 0;
  int unsigned sink_pause = 0;
  bit          sink_lazy  = 1'b1;
  bit          sink_hold  = 1'b0;

  // shadow of the block: registers and both rate tables
  logic [15:0] thr_now = THRESHOLD_RST;
  logic [15:0] win_now = WINDOW_RST;
  logic [15:0] shared_cnt [SOURCE_SLOTS_DEF];
  logic [31:0] shared_since [SOURCE_SLOTS_DEF];
  logic [15:0] udp_cnt [SOURCE_SLOTS_DEF];
  logic [31:0] udp_since [SOURCE_SLOTS_DEF];

  string verdict_names [6] = '{"suspicious", "rate_alert", "flag_alert", "empty_alert",
                               "size_alert", "icmp_alert"};

  // frame sizes sitting on either side of the guards and limits
  int unsigned frame_marks [20] = '{0, 33, 34, 37, 38, 39, 40, 41, 42, 49, 50, 53, 54,
                                    93, 94, 576, 577, 1500, 1501, 65535};

  // fixed-window counter for one slot; returns 1 when the threshold is crossed
  function automatic logic bump_rate(input logic udp_side, input int unsigned slot,
                                     input logic [31:0] now);
    logic [15:0] c;
    logic [31:0] since;
    logic [31:0] elapsed;
    logic        hit;
    c     = udp_side ? udp_cnt[slot] : shared_cnt[slot];
    since = udp_side ? udp_since[slot] : shared_since[slot];
    hit   = 1'b0;
    elapsed = now - since;
    if (c == 16'd0) begin
      since = now;
      c     = 16'd1;
    end else if (elapsed > {16'd0, win_now}) begin
      since = now;
      c     = 16'd1;
    end else begin
      if (c != 16'hFFFF) c = c + 16'd1;
      if (c > thr_now) begin
        c   = 16'd0;
        hit = 1'b1;
      end
    end
    if (udp_side) begin
      udp_cnt[slot]   = c;
      udp_since[slot] = since;
    end else begin
      shared_cnt[slot]   = c;
      shared_since[slot] = since;
    end
    return hit;
  endfunction

  // verdict for one header; updates the rate tables as a side effect
  function automatic logic [5:0] judge_header(input hdr_t h);
    int unsigned frame;
    int unsigned ihl;
    int unsigned toff;
    logic        syn, fin, rst_f, ack, urg;
    logic [5:0]  v;
    frame = h.frame_len;
    ihl   = h.ihl_words * 4;
    toff  = h.tcp_off * 4;
    syn   = h.flags[FLAG_SYN];
    fin   = h.flags[FLAG_FIN];
    rst_f = h.flags[FLAG_RST];
    ack   = h.flags[FLAG_ACK];
    urg   = h.flags[FLAG_URG];
    v     = '0;
    case (h.proto)
      PROTO_TCP: begin
        v[V_RATE] = bump_rate(1'b0, h.slot, h.now_s);
        if (frame >= ETH_BYTES + IP_MIN_BYTES + TCP_MIN_BYTES &&
            frame >= ETH_BYTES + ihl + TCP_MIN_BYTES)
          v[V_FLAG] = (syn && fin) || (syn && rst_f) || (fin && !ack) || (urg && !ack);
        if (frame >= ETH_BYTES + IP_MIN_BYTES && frame >= ETH_BYTES + ihl + TCP_MIN_BYTES)
          v[V_EMPTY] = (h.ip_len == ihl + toff);
      end
      PROTO_UDP: begin
        v[V_RATE] = bump_rate(1'b1, h.slot, h.now_s);
        if (frame >= ETH_BYTES + IP_MIN_BYTES + UDP_HDR_BYTES &&
            frame >= ETH_BYTES + ihl + UDP_HDR_BYTES)
          v[V_EMPTY] = (h.udp_len == UDP_HDR_BYTES);
        v[V_SIZE] = (frame < UDP_FRAME_MIN) || (frame > UDP_FRAME_MAX);
      end
      PROTO_ICMP: begin
        v[V_RATE] = bump_rate(1'b0, h.slot, h.now_s);
        v[V_ICMP] = (frame >= ETH_BYTES + IP_MIN_BYTES + ICMP_HDR_BYTES) &&
                    (h.icmp_type > ICMP_TYPE_MAX);
      end
      default: ;
    endcase
    if (frame < FRAME_MIN || frame > FRAME_MAX) v[V_SIZE] = 1'b1;
    v[V_SUSP] = |v[V_ICMP:V_RATE];
    return v;
  endfunction

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // monitor: register writes, header transfers and verdict transfers, all
  // sampled at the rising edge
  always @(posedge clk) begin
    hdr_xfer <= !rst && s_tvalid && s_tready;
    res_xfer <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW) win_now <= pwdata[15:0];
        else thr_now <= pwdata[15:0];
      end
      if (s_tvalid && s_tready) begin
        verdict_q.push_back(judge_header(s_tdata[113:0]));
        hdrs_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict 0x%02h with no header outstanding", m_tdata);
          mismatches++;
        end else begin
          logic [5:0] want;
          want = verdict_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (m_tdata[k] !== want[k]) begin
              $error("%s: expected %0b, got %0b", verdict_names[k], want[k], m_tdata[k]);
              mismatches++;
            end
          end
        end
      end
    end
  end

  // header driver: holds a transfer until taken, then waits its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || hdr_xfer) begin
      if (src_gap != 0) begin
        s_tvalid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (hdr_q.size() != 0) begin
        s_tdata  <= {6'd0, hdr_q.pop_front()};
        s_tvalid <= 1'b1;
        src_gap  <= src_lazy ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 15) == 0) src_lazy <= !src_lazy;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // verdict receiver: a drawn stall after each transfer, or a long hold-off
  always @(negedge clk) begin
    if (rst || sink_hold) begin
      m_tready <= 1'b0;
    end else if (res_xfer) begin
      sink_pause = sink_lazy ? $urandom_range(0, 17) : 0;
      m_tready  <= (sink_pause == 0);
      sink_wait <= (sink_pause == 0) ? 0 : sink_pause - 1;
      if ($urandom_range(0, 15) == 0) sink_lazy <= !sink_lazy;
    end else if (sink_wait != 0) begin
      m_tready  <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_hdr(input hdr_t h);
    hdr_q.push_back(h);
    hdrs_queued++;
  endtask

  // write a register, then read it back
  task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== val) begin
      $error("prdata: expected 0x%04h, got 0x%04h", val, prdata[15:0]);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // block until every header has gone in and every verdict has come out
  task automatic drain();
    while (hdrs_taken != hdrs_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic hdr_t hdr_of(input proto_t p, input int unsigned frame,
                                  input int unsigned ihl_w, input int unsigned iplen,
                                  input int unsigned toff_w, input logic [7:0] flags,
                                  input int unsigned ulen, input int unsigned itype,
                                  input int unsigned slot, input logic [31:0] now);
    hdr_t h;
    h.proto     = p;
    h.frame_len = 16'(frame);
    h.ihl_words = 4'(ihl_w);
    h.ip_len    = 16'(iplen);
    h.tcp_off   = 4'(toff_w);
    h.flags     = flags;
    h.udp_len   = 16'(ulen);
    h.icmp_type = 8'(itype);
    h.slot      = 8'(slot);
    h.now_s     = now;
    return h;
  endfunction

  // mostly plausible header with random content, aimed at the guards and
  // at a handful of busy slots
  function automatic hdr_t shaped_hdr(input logic [31:0] now);
    hdr_t h;
    h.now_s = now;
    case ($urandom_range(0, 9))
      0:             h.proto = PROTO_OTHER;
      1, 2, 3, 4:    h.proto = PROTO_TCP;
      5, 6, 7:       h.proto = PROTO_UDP;
      default:       h.proto = PROTO_ICMP;
    endcase
    h.ihl_words = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
    h.tcp_off   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
    case ($urandom_range(0, 5))
      0, 1:    h.frame_len = 16'(frame_marks[$urandom_range(0, 19)]);
      2:       h.frame_len = 16'($urandom_range(0, 65535));
      default: h.frame_len = 16'($urandom_range(40, 1500));
    endcase
    h.ip_len    = ($urandom_range(0, 2) == 0) ? 16'(h.ihl_words * 4 + h.tcp_off * 4)
                                               : 16'($urandom_range(0, 65535));
    h.flags     = 8'($urandom_range(0, 255));
    h.udp_len   = ($urandom_range(0, 2) == 0) ? 16'(UDP_HDR_BYTES)
                                               : 16'($urandom_range(0, 65535));
    h.icmp_type = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(16, 21))
                                               : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       h.slot = 8'($urandom_range(0, 255));
      1:       h.slot = 8'd255;
      default: h.slot = 8'($urandom_range(0, 2));
    endcase
    return h;
  endfunction

  // one setting of the registers and a burst of random traffic under it
  task automatic run_phase(input logic [15:0] thr, input logic [15:0] win,
                           input int unsigned count, input logic [31:0] start_t,
                           input bit hold_sink);
    logic [31:0]  now;
    logic [127:0] raw;
    write_reg(ADDR_THRESHOLD, thr);
    write_reg(ADDR_WINDOW, win);
    now = start_t;
    if (hold_sink) begin
      // receiver stalls for a long stretch while headers keep coming
      fork
        begin
          sink_hold = 1'b1;
          repeat (300) @(posedge clk);
          sink_hold = 1'b0;
        end
      join_none
    end
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0:          now = $urandom;
        1, 2, 3, 4: now = now + $urandom_range(0, win + 2);
        default:    ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        push_hdr(raw[113:0]);
      end else begin
        push_hdr(shaped_hdr(now));
      end
    end
    // sender pauses here until every verdict is back
    drain();
  endtask

  initial begin
    for (int s = 0; s < SOURCE_SLOTS_DEF; s++) begin
      shared_cnt[s]   = '0;
      shared_since[s] = '0;
      udp_cnt[s]      = '0;
      udp_since[s]    = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed pass: threshold 1 so every second packet in a window alerts,
    // window 2 so restarts are easy to provoke
    write_reg(ADDR_THRESHOLD, 16'd1);
    write_reg(ADDR_WINDOW, 16'd2);
    // flag combinations and their guard
    push_hdr(hdr_of(PROTO_TCP, 54, 5, 0, 5, F_SYN | F_FIN, 0, 0, 10, 100));
    push_hdr(hdr_of(PROTO_TCP, 1500, 5, 0, 5, F_SYN | F_RST, 0, 0, 10, 100));
    push_hdr(hdr_of(PROTO_TCP, 53, 5, 0, 5, F_FIN, 0, 0, 10, 100));
    push_hdr(hdr_of(PROTO_TCP, 93, 15, 0, 5, F_URG, 0, 0, 11, 100));
    push_hdr(hdr_of(PROTO_TCP, 94, 15, 80, 5, F_URG, 0, 0, 11, 100));
    push_hdr(hdr_of(PROTO_TCP, 60, 5, 40, 5, F_URG | F_ACK | F_FIN, 0, 0, 12, 100));
    // empty TCP payload either side of its guard
    push_hdr(hdr_of(PROTO_TCP, 33, 0, 0, 0, F_FIN, 0, 0, 12, 100));
    push_hdr(hdr_of(PROTO_TCP, 34, 0, 0, 0, 8'd0, 0, 0, 13, 100));
    // UDP empty payload and size window
    push_hdr(hdr_of(PROTO_UDP, 42, 5, 0, 5, 8'd0, 8, 0, 0, 0));
    push_hdr(hdr_of(PROTO_UDP, 41, 5, 0, 5, 8'd0, 8, 0, 0, 100));
    push_hdr(hdr_of(PROTO_UDP, 50, 7, 0, 5, 8'd0, 8, 0, 1, 0));
    push_hdr(hdr_of(PROTO_UDP, 576, 5, 0, 5, 8'd0, 9, 0, 1, 0));
    push_hdr(hdr_of(PROTO_UDP, 577, 5, 0, 5, 8'd0, 9, 0, 2, 0));
    push_hdr(hdr_of(PROTO_UDP, 49, 5, 0, 5, 8'd0, 9, 0, 2, 0));
    // ICMP type limit; ICMP and TCP count in the same table, UDP apart
    push_hdr(hdr_of(PROTO_ICMP, 38, 5, 0, 5, 8'd0, 0, 19, 20, 0));
    push_hdr(hdr_of(PROTO_TCP, 100, 5, 0, 5, F_ACK, 0, 0, 20, 0));
    push_hdr(hdr_of(PROTO_UDP, 100, 5, 0, 5, 8'd0, 100, 0, 20, 0));
    push_hdr(hdr_of(PROTO_ICMP, 37, 5, 0, 5, 8'd0, 0, 255, 21, 0));
    push_hdr(hdr_of(PROTO_ICMP, 1500, 5, 0, 5, 8'd0, 0, 18, 21, 0));
    // other protocol: general frame limits only, no counting
    push_hdr(hdr_of(PROTO_OTHER, 39, 5, 0, 5, 8'hFF, 8, 255, 10, 100));
    push_hdr(hdr_of(PROTO_OTHER, 40, 5, 0, 5, 8'd0, 8, 0, 10, 100));
    push_hdr(hdr_of(PROTO_OTHER, 65535, 15, 65535, 15, 8'hFF, 65535, 255, 10, 100));
    // window restart after it runs out, then an alert just inside it
    push_hdr(hdr_of(PROTO_TCP, 100, 5, 0, 5, F_ACK, 0, 0, 10, 103));
    push_hdr(hdr_of(PROTO_TCP, 100, 5, 0, 5, F_ACK, 0, 0, 10, 105));
    // time wrapping past zero stays inside the window
    push_hdr(hdr_of(PROTO_UDP, 100, 5, 0, 5, 8'd0, 100, 0, 255, 32'hFFFF_FFFF));
    push_hdr(hdr_of(PROTO_UDP, 1500, 15, 65535, 15, 8'hFF, 65535, 255, 255, 1));
    drain();

    // random traffic under a spread of settings, extremes included
    run_phase(16'd0, 16'd0, 70, $urandom, 1'b0);
    run_phase(16'd3, 16'd5, 80, $urandom, 1'b1);
    run_phase(16'd65534, 16'd65535, 60, 32'hFFFF_FFF0, 1'b0);
    run_phase(16'd2, 16'd1, 70, $urandom, 1'b0);
    run_phase(THRESHOLD_RST, WINDOW_RST, 60, $urandom, 1'b0);
    run_phase(16'd7, 16'd30, 70, $urandom, 1'b0);
    run_phase(16'd0, 16'd65535, 70, 32'hFFFF_FFF0, 1'b0);
    run_phase(16'd65534, 16'd0, 60, $urandom, 1'b0);

    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
    end
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
